[hdl/loop_sampler_playback_sequencer_macros.svh]
// Assertion macros for the sequencer execution module.
`ifndef LOOP_SAMPLER_PLAYBACK_SEQUENCER_MACROS_SVH
`define LOOP_SAMPLER_PLAYBACK_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequencer check failed");

`endif

[hdl/lsps_pkg.sv]
package lsps_pkg;

	localparam int DEF_BANK_DEPTH = 65536;
	localparam int DEF_PART_LIMIT = 16;

	// Part count is always a power of two; only its exponent is kept.
	localparam int PART_EXP_W = 3;

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_SELECT = 3'd2;
	localparam logic [2:0] CMD_PARTS  = 3'd3;
	localparam logic [2:0] CMD_PAUSE  = 3'd4;
	localparam logic [2:0] CMD_ARM    = 3'd5;
	localparam logic [2:0] CMD_BG     = 3'd6;

	localparam logic CFG_MUTED  = 1'b0;
	localparam logic CFG_VOLUME = 1'b1;

	localparam logic [10:0] VOLUME_RESET = 11'd1024;

	typedef struct packed {
		logic [2:0]  command;
		logic [23:0] play_position;
		logic [15:0] write_address;
		logic        write_bank;
		logic [15:0] write_value;
		logic [15:0] select_start;
		logic [16:0] select_end;
		logic        flag_value;
		logic [16:0] loaded_length;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [23:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

endpackage

[hdl/loop_sampler_playback_sequencer.sv]
// Loop sampler playback sequencer.
// Input requests arrive on in_valid/in_ready with a command and its fields; they go into
// a two-entry queue and are carried out one at a time by the back end. Only a tick
// (command zero) makes a result, delivered on out_valid/out_ready; all other commands
// are silent and codes beyond background loaded are dropped.
// Settings are written on cfg_valid/cfg_ready (always ready): index 0 is mute, index 1
// the volume numerator with 1024 as unity. Write them only while the block is idle.
// A tick with a sample loaded goes through the shared 24-step restoring divider, used
// once for the loop wrap and once for the part boundary test, then the sample memory
// read and the gain multiply. A tick with an empty or inverted loop skips the first
// division. Other commands are carried out in the back end's idle state, and the back
// end takes no new item until the current one is done; the queue takes requests meanwhile.
// Reset clears all playback state and the queue; volume returns to unity and mute to off.
// The sample memory is not cleared and holds garbage until written.
// When the receiver stalls, the finished result waits in the output register while the
// queue keeps taking requests; the next tick waits at its last step until that register
// frees up.
module loop_sampler_playback_sequencer #(
	parameter int BANK_DEPTH = lsps_pkg::DEF_BANK_DEPTH,
	parameter int PART_LIMIT = lsps_pkg::DEF_PART_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic [23:0]        play_position,
	input  logic [15:0]        write_address,
	input  logic               write_bank,
	input  logic signed [15:0] write_value,
	input  logic [15:0]        select_start,
	input  logic [16:0]        select_end,
	input  logic               flag_value,
	input  logic [16:0]        loaded_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out,
	output logic [15:0]        current_position,
	output logic               at_part_start,
	output logic               banks_switched,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_data
);

	lsps_pkg::item_t    in_item;
	lsps_pkg::item_t    q_item;
	lsps_pkg::div_req_t div_req;
	logic               q_valid;
	logic               q_pop;
	logic               div_done;
	logic [16:0]        div_rem;
	logic               muted_q;
	logic [10:0]        volume_q;

	assign in_item.command       = command;
	assign in_item.play_position = play_position;
	assign in_item.write_address = write_address;
	assign in_item.write_bank    = write_bank;
	assign in_item.write_value   = write_value;
	assign in_item.select_start  = select_start;
	assign in_item.select_end    = select_end;
	assign in_item.flag_value    = flag_value;
	assign in_item.loaded_length = loaded_length;

	// The settings registers accept a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			muted_q  <= 1'b0;
			volume_q <= lsps_pkg::VOLUME_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				lsps_pkg::CFG_MUTED:  muted_q  <= cfg_data[0];
				lsps_pkg::CFG_VOLUME: volume_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lsps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.item_valid (q_valid),
		.item       (q_item),
		.item_pop   (q_pop)
	);

	lsps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.rem    (div_rem)
	);

	lsps_exec #(
		.BANK_DEPTH (BANK_DEPTH),
		.PART_LIMIT (PART_LIMIT)
	) u_exec (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (q_valid),
		.item             (q_item),
		.item_pop         (q_pop),
		.muted            (muted_q),
		.volume_level     (volume_q),
		.div_req          (div_req),
		.div_done         (div_done),
		.div_rem          (div_rem),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sample_out       (sample_out),
		.current_position (current_position),
		.at_part_start    (at_part_start),
		.banks_switched   (banks_switched)
	);

endmodule

[hdl/lsps_front.sv]
module lsps_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsps_pkg::item_t   in_item,
	output logic              item_valid,
	output lsps_pkg::item_t   item,
	input  logic              item_pop
);

	lsps_pkg::item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       known;
	logic       push;
	logic       pop;

	// Codes beyond the command list do nothing, so they are dropped here.
	assign known      = (in_item.command <= lsps_pkg::CMD_BG);
	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready && known;
	assign item_valid = (count_q != 2'd0);
	assign pop        = item_pop && item_valid;
	assign item       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[hdl/lsps_div.sv]
module lsps_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsps_pkg::div_req_t   req,
	output logic                 done,
	output logic [16:0]          rem
);

	logic [23:0] dvd_q;
	logic [16:0] dvs_q;
	logic [16:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;
	logic [17:0] diff;

	// One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
	assign trial = {rem_q, dvd_q[23]};
	assign diff  = trial - {1'b0, dvs_q};
	assign done  = done_q;
	assign rem   = rem_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[22:0], 1'b0};
			rem_q <= diff[17] ? trial[16:0] : diff[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd23);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

[hdl/lsps_exec.sv]
`include "loop_sampler_playback_sequencer_macros.svh"

module lsps_exec #(
	parameter int BANK_DEPTH = lsps_pkg::DEF_BANK_DEPTH,
	parameter int PART_LIMIT = lsps_pkg::DEF_PART_LIMIT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  lsps_pkg::item_t     item,
	output logic                item_pop,
	input  logic                muted,
	input  logic [10:0]         volume_level,
	output lsps_pkg::div_req_t  div_req,
	input  logic                div_done,
	input  logic [16:0]         div_rem,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  sample_out,
	output logic [15:0]         current_position,
	output logic                at_part_start,
	output logic                banks_switched
);

	localparam int AW = $clog2(BANK_DEPTH);
	localparam logic [24:0] DEPTH_V = 25'(BANK_DEPTH);
	localparam int PART_EXP_W_L = lsps_pkg::PART_EXP_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DIV1  = 8'b0000_0010,
		S_BND   = 8'b0000_0100,
		S_DIV2  = 8'b0000_1000,
		S_APPLY = 8'b0001_0000,
		S_READ  = 8'b0010_0000,
		S_MUL   = 8'b0100_0000,
		S_SCALE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [15:0] mem [2**(AW+1)];

	logic        bank_q;
	logic        present_q;
	logic [16:0] length_q;
	logic [15:0] pos_q;
	logic [15:0] a_start_q;
	logic [16:0] a_end_q;
	logic [15:0] p_start_q;
	logic [16:0] p_end_q;
	logic [PART_EXP_W_L-1:0] part_k_q;
	logic        hold_q;
	logic        armed_q;
	logic        bg_ready_q;
	logic [16:0] bg_length_q;
	logic        bnd_q;
	logic        sw_q;
	logic        zero_q;
	logic        oob_q;
	logic [15:0] rd_q;
	logic signed [27:0] prod_q;

	logic               out_valid_q;
	logic signed [15:0] sample_q;
	logic [15:0]        cur_pos_q;
	logic               bnd_out_q;
	logic               sw_out_q;

	// Tick loop selection, evaluated when the tick leaves the queue.
	logic        adopt;
	logic [15:0] n_start;
	logic [16:0] n_end;
	logic [16:0] loop_len;
	logic [16:0] part_size;
	logic [23:0] wr_addr_ext;
	logic [23:0] rd_addr_ext;
	logic        fg_now;
	logic [16:0] fg_len;
	logic        split_wrap;
	logic [27:0] biased;
	logic signed [27:0] scaled;
	logic signed [15:0] sat;
	logic        can_out;
	logic        load_out;

	assign adopt = (item.play_position == 24'd0)
		|| ((a_end_q != 17'd0) && ({1'b0, pos_q} == a_end_q - 17'd1))
		|| ((pos_q >= p_start_q) && ({1'b0, pos_q} < p_end_q));
	assign n_start   = adopt ? p_start_q : a_start_q;
	assign n_end     = adopt ? p_end_q : a_end_q;
	assign loop_len  = n_end - {1'b0, n_start};
	assign part_size = length_q >> part_k_q;
	assign wr_addr_ext = {8'd0, item.write_address};
	assign rd_addr_ext = {8'd0, pos_q};
	assign split_wrap  = (32'd1 << ({1'b0, part_k_q} + 4'd1)) > 32'(PART_LIMIT);
	assign can_out     = !out_valid_q || out_ready;
	assign load_out    = (state_q == S_SCALE) && can_out;

	// Bank swap either on a background announce with nothing playing, or at a boundary.
	assign fg_now = ((state_q == S_IDLE) && item_valid && (item.command == lsps_pkg::CMD_BG)
			&& !present_q)
		|| ((state_q == S_APPLY) && bnd_q && armed_q && bg_ready_q);
	assign fg_len = (state_q == S_APPLY) ? bg_length_q : item.loaded_length;

	// Divide by 1024 truncating toward zero, then saturate.
	assign biased = prod_q + (prod_q[27] ? 28'd1023 : 28'd0);
	assign scaled = $signed(biased) >>> 10;
	always_comb begin
		if (scaled > 28'sd32767) begin
			sat = 16'sh7fff;
		end else if (scaled < -28'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = scaled[15:0];
		end
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = item.play_position;
		div_req.divisor  = loop_len;
		if ((state_q == S_IDLE) && item_valid && (item.command == lsps_pkg::CMD_TICK)
				&& present_q && (n_end > {1'b0, n_start})) begin
			div_req.start = 1'b1;
		end else if ((state_q == S_BND) && (part_size != 17'd0)) begin
			div_req.start    = 1'b1;
			div_req.dividend = {8'd0, pos_q};
			div_req.divisor  = part_size;
		end
	end

	assign item_pop = (state_q == S_IDLE) && item_valid;

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && item_valid && (item.command == lsps_pkg::CMD_WRITE)
				&& ({1'b0, wr_addr_ext} < DEPTH_V)) begin
			mem[{item.write_bank, wr_addr_ext[AW-1:0]}] <= item.write_value;
		end
		if (state_q == S_READ) begin
			rd_q  <= mem[{bank_q, rd_addr_ext[AW-1:0]}];
			oob_q <= ({1'b0, rd_addr_ext} >= DEPTH_V);
		end
		if (state_q == S_MUL) begin
			prod_q <= oob_q ? 28'sd0 : $signed(rd_q) * $signed({1'b0, volume_level});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bank_q      <= 1'b0;
			present_q   <= 1'b0;
			length_q    <= '0;
			pos_q       <= '0;
			a_start_q   <= '0;
			a_end_q     <= '0;
			p_start_q   <= '0;
			p_end_q     <= '0;
			part_k_q    <= '0;
			hold_q      <= 1'b0;
			armed_q     <= 1'b0;
			bg_ready_q  <= 1'b0;
			bg_length_q <= '0;
			bnd_q       <= 1'b0;
			sw_q        <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
			cur_pos_q   <= '0;
			bnd_out_q   <= 1'b0;
			sw_out_q    <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						case (item.command)
							lsps_pkg::CMD_TICK: begin
								bnd_q <= 1'b0;
								sw_q  <= 1'b0;
								if (!present_q) begin
									zero_q  <= 1'b1;
									state_q <= S_SCALE;
								end else begin
									zero_q    <= 1'b0;
									a_start_q <= n_start;
									a_end_q   <= n_end;
									if (n_end > {1'b0, n_start}) begin
										state_q <= S_DIV1;
									end else begin
										pos_q   <= n_start;
										state_q <= S_BND;
									end
								end
							end
							lsps_pkg::CMD_SELECT: begin
								p_start_q <= item.select_start;
								p_end_q   <= item.select_end;
							end
							lsps_pkg::CMD_PARTS: begin
								if (present_q) begin
									part_k_q <= split_wrap ? '0
										: part_k_q + PART_EXP_W_L'(1);
								end
							end
							lsps_pkg::CMD_PAUSE: begin
								hold_q <= item.flag_value;
							end
							lsps_pkg::CMD_ARM: begin
								armed_q <= item.flag_value;
							end
							lsps_pkg::CMD_BG: begin
								if (present_q) begin
									bg_ready_q  <= 1'b1;
									bg_length_q <= item.loaded_length;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV1: begin
					if (div_done) begin
						pos_q   <= div_rem[15:0] + a_start_q;
						state_q <= S_BND;
					end
				end
				S_BND: begin
					if (part_size != 17'd0) begin
						state_q <= S_DIV2;
					end else begin
						bnd_q   <= (pos_q == 16'd0);
						state_q <= S_APPLY;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						bnd_q   <= (div_rem == 17'd0);
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					// A swap clears hold along with the rest of the state below.
					if (bnd_q && !fg_now) begin
						hold_q <= 1'b0;
					end
					sw_q    <= fg_now;
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (can_out) begin
						sample_q    <= (zero_q || muted || hold_q) ? 16'sd0 : sat;
						cur_pos_q   <= zero_q ? 16'd0 : pos_q;
						bnd_out_q   <= zero_q ? 1'b0 : bnd_q;
						sw_out_q    <= zero_q ? 1'b0 : sw_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fg_now) begin
				bank_q     <= ~bank_q;
				present_q  <= 1'b1;
				length_q   <= fg_len;
				pos_q      <= '0;
				part_k_q   <= '0;
				a_start_q  <= '0;
				a_end_q    <= fg_len;
				p_start_q  <= '0;
				p_end_q    <= fg_len;
				hold_q     <= 1'b0;
				armed_q    <= 1'b0;
				bg_ready_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign sample_out       = sample_q;
	assign current_position = cur_pos_q;
	assign at_part_start    = bnd_out_q;
	assign banks_switched   = sw_out_q;

	`LSPS_ASSERT_NEXT(a_div1_exit, (state_q == S_DIV1) && div_done, state_q == S_BND)
	`LSPS_ASSERT_NOW(a_div_start_place, div_req.start,
		(state_q == S_IDLE) || (state_q == S_BND))
	`LSPS_ASSERT_NOW(a_part_limit, 1'b1, (32'd1 << part_k_q) <= 32'(PART_LIMIT))
	`LSPS_ASSERT_NOW(a_switch_needs_boundary, fg_now && (state_q == S_APPLY), bnd_q)

endmodule

[tb/sv/tb_loop_sampler_playback_sequencer.sv]
`timescale 1ns / 1ps

// Self-checking bench for the loop sampler playback sequencer.
// Requests go in on one valid/ready channel and tick results come back on another.
// A behavioral copy of the sequencer runs alongside the block. It predicts every tick
// result at the moment the tick request is accepted. A checker process compares each
// returned result with the oldest prediction.
module tb_loop_sampler_playback_sequencer;

	localparam int CYCLE_LIMIT  = 1000000;
	// Quiet time that lets silent commands and an in-flight tick finish.
	localparam int SETTLE_CYCLES = 80;
	// A command code past the defined list; the block must ignore it.
	localparam logic [2:0] CMD_UNKNOWN = 3'd7;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [15:0]        position;
		logic               part_start;
		logic               switched;
	} tick_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         command;
	logic [23:0]        play_position;
	logic [15:0]        write_address;
	logic               write_bank;
	logic signed [15:0] write_value;
	logic [15:0]        select_start;
	logic [16:0]        select_end;
	logic               flag_value;
	logic [16:0]        loaded_length;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample_out;
	logic [15:0]        current_position;
	logic               at_part_start;
	logic               banks_switched;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [10:0]        cfg_data;

	loop_sampler_playback_sequencer DUT (.*);

	// Shadow of the sequencer state, kept at reset values until requests arrive.
	shortint     shadow_mem[int];
	logic        fg_bank      = 1'b0;
	bit          have_sample  = 1'b0;
	int unsigned fg_length    = 0;
	int unsigned play_idx     = 0;
	int unsigned loop_lo      = 0;
	int unsigned loop_hi      = 0;
	int unsigned next_lo      = 0;
	int unsigned next_hi      = 0;
	int unsigned parts        = 1;
	bit          held         = 1'b0;
	bit          armed        = 1'b0;
	bit          bg_waiting   = 1'b0;
	int unsigned bg_length    = 0;
	bit          mute_on      = 1'b0;
	int unsigned gain         = 1024;

	tick_result_t expected_ticks[$];
	int errors       = 0;
	int ticks_seen   = 0;
	int requests_out = 0;
	int switches     = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Bring the background bank forward and restart the loop over its full length.
	function automatic void promote_background(input int unsigned len);
		fg_bank     = ~fg_bank;
		have_sample = 1'b1;
		fg_length   = len;
		play_idx    = 0;
		parts       = 1;
		loop_lo     = 0;
		loop_hi     = len;
		next_lo     = 0;
		next_hi     = len;
		held        = 1'b0;
		armed       = 1'b0;
		bg_waiting  = 1'b0;
	endfunction

	// Predict one tick. With update clear it only reports which store entry the tick
	// will read, so the stimulus can fill that entry first.
	function automatic void play_tick(input logic [23:0] pos, input bit update,
			output tick_result_t res, output int rd_addr);
		int unsigned lo, hi, idx, part_size;
		bit boundary, swap, silent;
		logic bank;
		int s;
		res = '0;
		rd_addr = 0;
		if (!have_sample)
			return;
		lo = loop_lo;
		hi = loop_hi;
		// Adopt the pending subloop at loop start, at subloop end, or once inside it.
		if (pos == 0 || (hi != 0 && play_idx == hi - 1) ||
				(play_idx >= next_lo && play_idx < next_hi)) begin
			lo = next_lo;
			hi = next_hi;
		end
		if (hi > lo)
			idx = (pos % (hi - lo) + lo) & 32'hFFFF;
		else
			idx = lo & 32'hFFFF;
		part_size = fg_length / parts;
		boundary  = (part_size != 0) ? (idx % part_size == 0) : (idx == 0);
		swap      = boundary && armed && bg_waiting;
		silent    = mute_on || (held && !boundary);
		bank      = fg_bank ^ swap;
		if (swap)
			idx = 0;
		rd_addr = {bank, idx[15:0]};
		if (update) begin
			loop_lo  = lo;
			loop_hi  = hi;
			play_idx = idx;
			if (boundary)
				held = 1'b0;
			if (swap)
				promote_background(bg_length);
		end
		s = shadow_mem.exists(rd_addr) ? int'(shadow_mem[rd_addr]) : 0;
		if (silent) begin
			s = 0;
		end else begin
			s = (s * int'(gain)) / 1024;
			if (s > 32767)
				s = 32767;
			if (s < -32768)
				s = -32768;
		end
		res.sample     = s[15:0];
		res.position   = idx[15:0];
		res.part_start = boundary;
		res.switched   = swap;
	endfunction

	// Fold one accepted request into the shadow state.
	function automatic void apply_request(input lsps_pkg::item_t req);
		tick_result_t res;
		int addr;
		case (req.command)
			lsps_pkg::CMD_TICK: begin
				play_tick(req.play_position, 1'b1, res, addr);
				expected_ticks.push_back(res);
				if (res.switched)
					switches++;
			end
			lsps_pkg::CMD_WRITE:
				shadow_mem[{req.write_bank, req.write_address}] = req.write_value;
			lsps_pkg::CMD_SELECT: begin
				next_lo = req.select_start;
				next_hi = req.select_end;
			end
			lsps_pkg::CMD_PARTS: begin
				if (have_sample) begin
					parts = parts * 2;
					if (parts > lsps_pkg::DEF_PART_LIMIT)
						parts = 1;
				end
			end
			lsps_pkg::CMD_PAUSE: held = req.flag_value;
			lsps_pkg::CMD_ARM: armed = req.flag_value;
			lsps_pkg::CMD_BG: begin
				if (!have_sample) begin
					promote_background(req.loaded_length);
				end else begin
					bg_waiting = 1'b1;
					bg_length  = req.loaded_length;
				end
			end
			default: ;
		endcase
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Send one request; the payload is held until the block takes it.
	task automatic send_request(input lsps_pkg::item_t req);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command       = req.command;
		play_position = req.play_position;
		write_address = req.write_address;
		write_bank    = req.write_bank;
		write_value   = req.write_value;
		select_start  = req.select_start;
		select_end    = req.select_end;
		flag_value    = req.flag_value;
		loaded_length = req.loaded_length;
		in_valid      = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_request(req);
		requests_out++;
	endtask

	function automatic lsps_pkg::item_t random_fields();
		logic [127:0] bits;
		bits = {$urandom(), $urandom(), $urandom(), $urandom()};
		return bits[$bits(lsps_pkg::item_t)-1:0];
	endfunction

	task automatic send_cmd(input logic [2:0] cmd, input lsps_pkg::item_t fields);
		fields.command = cmd;
		send_request(fields);
	endtask

	// A tick never reads a store entry that was not written: fill it first if needed.
	task automatic send_tick(input logic [23:0] pos);
		lsps_pkg::item_t req;
		tick_result_t res;
		int addr;
		play_tick(pos, 1'b0, res, addr);
		if (have_sample && !shadow_mem.exists(addr)) begin
			req = random_fields();
			req.write_bank    = addr[16];
			req.write_address = addr[15:0];
			send_cmd(lsps_pkg::CMD_WRITE, req);
		end
		req = random_fields();
		req.play_position = pos;
		send_cmd(lsps_pkg::CMD_TICK, req);
	endtask

	task automatic send_write(input logic bank, input logic [15:0] addr,
			input logic [15:0] value);
		lsps_pkg::item_t req;
		req = random_fields();
		req.write_bank    = bank;
		req.write_address = addr;
		req.write_value   = value;
		send_cmd(lsps_pkg::CMD_WRITE, req);
	endtask

	task automatic send_select(input logic [15:0] lo, input logic [16:0] hi);
		lsps_pkg::item_t req;
		req = random_fields();
		req.select_start = lo;
		req.select_end   = hi;
		send_cmd(lsps_pkg::CMD_SELECT, req);
	endtask

	task automatic send_flag(input logic [2:0] cmd, input logic value);
		lsps_pkg::item_t req;
		req = random_fields();
		req.flag_value = value;
		send_cmd(cmd, req);
	endtask

	task automatic send_loaded(input logic [16:0] len);
		lsps_pkg::item_t req;
		req = random_fields();
		req.loaded_length = len;
		send_cmd(lsps_pkg::CMD_BG, req);
	endtask

	// Wait until every predicted result is back and silent commands have drained.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input logic idx, input logic [10:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == lsps_pkg::CFG_MUTED)
			mute_on = value[0];
		else
			gain = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Ticks before anything is loaded must return all-zero results.
	task automatic test_empty_ticks();
		send_tick(24'd0);
		send_tick(24'hFFFFFF);
		send_flag(lsps_pkg::CMD_PARTS, 1'b0);
		send_tick(24'd5);
	endtask

	// Hand-picked requests: field extremes, every command and each corner case.
	task automatic test_directed();
		lsps_pkg::item_t req;
		// Announcing with nothing loaded brings the bank forward at once.
		send_loaded(17'd16);
		send_write(1'b1, 16'd0, 16'h7FFF);
		send_write(1'b1, 16'd3, 16'h8000);
		send_write(1'b0, 16'hFFFF, 16'h1234);
		send_tick(24'd0);
		send_tick(24'd3);
		send_tick(24'hFFFFFF);
		// Inverted loop, then a loop at the very top that wraps past 16 bits.
		send_select(16'd10, 17'd5);
		send_tick(24'd7);
		send_select(16'hFFFF, 17'h1FFFF);
		send_tick(24'd0);
		send_tick(24'd9);
		send_select(16'd0, 17'd16);
		send_tick(24'd0);
		// Splits walk the part count up to its limit and back to one.
		repeat (5) send_flag(lsps_pkg::CMD_PARTS, 1'b1);
		send_flag(lsps_pkg::CMD_PAUSE, 1'b1);
		send_tick(24'd3);
		send_tick(24'd4);
		// Armed switch with a waiting background bank swaps on the next boundary.
		send_flag(lsps_pkg::CMD_ARM, 1'b1);
		send_loaded(17'h10000);
		send_tick(24'd8);
		req = random_fields();
		send_cmd(CMD_UNKNOWN, req);
		send_tick(24'd1);
	endtask

	// Random traffic, mostly well-formed playback with random content.
	task automatic test_random(input int count);
		lsps_pkg::item_t req;
		int roll, len;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65536)
				: $urandom_range(1, 48);
			if (roll < 50) begin
				case ($urandom_range(0, 3))
					0: send_tick(24'd0);
					1: send_tick(24'($urandom_range(0, 200)));
					default: send_tick(24'($urandom()));
				endcase
			end else if (roll < 62) begin
				send_write(1'($urandom()), 16'($urandom_range(0, 63)), 16'($urandom()));
			end else if (roll < 72) begin
				if ($urandom_range(0, 4) == 0) begin
					send_select(16'($urandom()), 17'($urandom()));
				end else begin
					len = $urandom_range(0, fg_length > 0 ? fg_length - 1 : 0);
					send_select(16'(len), 17'(len + $urandom_range(1, 16)));
				end
			end else if (roll < 79) begin
				send_flag(lsps_pkg::CMD_PARTS, 1'($urandom()));
			end else if (roll < 85) begin
				send_flag(lsps_pkg::CMD_PAUSE, 1'($urandom()));
			end else if (roll < 91) begin
				send_flag(lsps_pkg::CMD_ARM, $urandom_range(0, 3) != 0);
			end else if (roll < 97) begin
				send_loaded(17'(len));
			end else begin
				req = random_fields();
				send_cmd(CMD_UNKNOWN, req);
			end
		end
	endtask

	// Receiver: ready runs broken by stalls, mostly short and sometimes long.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = 1'b1;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(100, 300)
					: $urandom_range(0, 8))
				@(negedge clk);
			out_ready = 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
					: $urandom_range(1, 3))
				@(negedge clk);
		end
	end

	// Compare every returned tick with the oldest prediction.
	always @(posedge clk) begin
		tick_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			ticks_seen++;
			if (expected_ticks.size() == 0) begin
				$error("tick result with no prediction waiting");
				errors++;
			end else begin
				exp_res = expected_ticks.pop_front();
				if (sample_out !== exp_res.sample) begin
					$error("sample_out expected %0d got %0d", exp_res.sample, sample_out);
					errors++;
				end
				if (current_position !== exp_res.position) begin
					$error("current_position expected %0d got %0d", exp_res.position,
						current_position);
					errors++;
				end
				if (at_part_start !== exp_res.part_start) begin
					$error("at_part_start expected %0d got %0d", exp_res.part_start,
						at_part_start);
					errors++;
				end
				if (banks_switched !== exp_res.switched) begin
					$error("banks_switched expected %0d got %0d", exp_res.switched,
						banks_switched);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		command       = lsps_pkg::CMD_TICK;
		play_position = '0;
		write_address = '0;
		write_bank    = 1'b0;
		write_value   = '0;
		select_start  = '0;
		select_end    = '0;
		flag_value    = 1'b0;
		loaded_length = '0;
		cfg_valid     = 1'b0;
		cfg_index     = lsps_pkg::CFG_MUTED;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_ticks();
		test_directed();
		settle();

		// Gain extremes: zero, unity, and the top code that drives saturation.
		write_setting(lsps_pkg::CFG_VOLUME, 11'd2047);
		test_random(110);
		settle();
		write_setting(lsps_pkg::CFG_MUTED, 11'd1);
		test_random(80);
		settle();
		write_setting(lsps_pkg::CFG_MUTED, 11'd0);
		write_setting(lsps_pkg::CFG_VOLUME, 11'd0);
		test_random(80);
		settle();
		write_setting(lsps_pkg::CFG_VOLUME, 11'd1024);
		test_random(150);
		settle();
		write_setting(lsps_pkg::CFG_VOLUME, 11'($urandom_range(1, 2046)));
		test_random(110);
		settle();

		if (expected_ticks.size() != 0) begin
			$error("%0d tick results never arrived", expected_ticks.size());
			errors++;
		end
		$display("Sent %0d requests, checked %0d tick results, %0d bank swaps.",
			requests_out, ticks_seen, switches);
		$display("Covered empty play, loop wrap, splits, hold, mute and gain extremes.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
